[rtl/core/rgblz_pkg.sv]
// Shared types, constants and the literal pixel expansion for the RGB555 LZ texture decoder.
`timescale 1ns / 1ps

package rgblz_pkg;

    localparam int WORD_W   = 16;
    localparam int COUNT_W  = 25;
    localparam int PIXEL_W  = 32;
    localparam int RUN_W    = 14;
    localparam int TDATA_W  = 48;
    localparam int CFG_IDX_W = 1;

    localparam int LIT_BIT = 15;
    localparam int REF_BIT = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_RED_BLUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT   = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_COPY,
        S_CLEAR,
        S_RUN_OUT
    } t_state;

    // Five-bit channel to eight bits, rounded to nearest: round(v * 255 / 31).
    localparam logic [7:0] EXPAND5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
        8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
        8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
        8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
    };

    function automatic logic [PIXEL_W-1:0] literal_pixel(
        input logic [WORD_W-1:0] word,
        input logic              swap
    );
        logic [7:0] hi;
        logic [7:0] mid;
        logic [7:0] lo;
        hi  = EXPAND5[word[14:10]];
        mid = EXPAND5[word[9:5]];
        lo  = EXPAND5[word[4:0]];
        if (swap) begin
            literal_pixel = {ALPHA_OPAQUE, hi, mid, lo};
        end else begin
            literal_pixel = {ALPHA_OPAQUE, lo, mid, hi};
        end
    endfunction

endpackage

[rtl/core/rgblz_hist_mem.sv]
// Pixel history ring: one write port and one registered read port.
`timescale 1ns / 1ps

module rgblz_hist_mem #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 32,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rgb555_lz_texture_decoder.sv]
// Top level of the RGB555 LZ texture decoder: word decode, copy and clear sequencer, output stage.
`timescale 1ns / 1ps

// Each 16-bit code word is taken when the block is idle and produces one literal RGBA pixel,
// up to nine copied RGBA pixels or one zero-run item covering up to 16383 pixels. A back-reference
// alternates a read and a copy state per copied pixel, because every pixel is read from the
// single history memory and written back before the next read, so overlapping copies see their
// own output. A zero run first clears each covered history entry, up to the whole 2048-entry
// ring, then emits its run item. The ring needs no clearing pass after reset: an entry that lies
// before the first pixel emitted since reset reads as zero by comparing the copy distance with
// the count of pixels emitted so far. A stalled output only delays the sequencer; the next code
// word is accepted while the last result still waits.

module rgb555_lz_texture_decoder #(
    parameter int HISTORY_DEPTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [rgblz_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rgblz_pkg::COUNT_W-1:0]     i_cfg_wdata,
    // Code word input.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [rgblz_pkg::WORD_W-1:0]      i_s_axis_tdata,   // [15:0] code_word
    // Pixel output.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [rgblz_pkg::TDATA_W-1:0]     o_m_axis_tdata,   // [31:0] pixel_rgba,
                                                                // [45:32] run_length, [47:46] zero
    output logic                              o_m_axis_tlast,   // last_of_word
    output logic                              o_m_axis_tuser    // image_done
);

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CLRW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW   = rgblz_pkg::COUNT_W;
    localparam int RW   = rgblz_pkg::RUN_W;
    localparam int PW   = rgblz_pkg::PIXEL_W;

    rgblz_pkg::t_state r_state, n_state;

    logic [rgblz_pkg::WORD_W-1:0] r_word, n_word;
    logic [CW-1:0]   r_emitted, n_emitted;
    logic            r_first, n_first;
    logic            r_swap;
    logic [CW-1:0]   r_pc;
    logic [3:0]      r_cnt, n_cnt;
    logic [RW-1:0]   r_run, n_run;
    logic [CLRW-1:0] r_clr, n_clr;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;

    logic            r_out_valid;
    logic [PW-1:0]   r_out_pixel;
    logic [RW-1:0]   r_out_run;
    logic            r_out_last;
    logic            r_out_done;

    logic            w_out_load;
    logic [PW-1:0]   w_load_pixel;
    logic [RW-1:0]   w_load_run;
    logic            w_load_last;
    logic            w_load_done;
    logic            w_out_free;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [PW-1:0]   mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [PW-1:0]   mem_rdata;

    logic [CW-1:0]   w_remaining;
    logic            w_image_full;
    logic [3:0]      w_ref_cnt_raw;
    logic [3:0]      w_ref_cnt;
    logic [RW-1:0]   w_run_clip;
    logic [11:0]     w_dist;
    logic            w_before_start;
    logic [CW-1:0]   w_emitted_inc;
    logic [PW-1:0]   w_copy_pixel;

    rgblz_hist_mem #(
        .DEPTH  (HISTORY_DEPTH),
        .DATA_W (PW),
        .AW     (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_out_free    = !r_out_valid || i_m_axis_tready;
    assign w_remaining   = r_pc - r_emitted;
    assign w_image_full  = (r_emitted >= r_pc);
    assign w_ref_cnt_raw = {1'b0, r_word[13:11]} + 4'd2;
    assign w_ref_cnt     = (w_remaining < CW'(w_ref_cnt_raw)) ? w_remaining[3:0] : w_ref_cnt_raw;
    assign w_run_clip    = (w_remaining < CW'(r_word[RW-1:0])) ? w_remaining[RW-1:0]
                                                               : r_word[RW-1:0];
    assign w_dist        = {1'b0, r_word[10:0]} + 12'd1;
    // Positions older than the first emitted pixel were never written and read as zero.
    assign w_before_start = (r_emitted < CW'(w_dist));
    assign w_emitted_inc = r_emitted + CW'(1);
    assign w_copy_pixel  = w_before_start ? '0 : mem_rdata;

    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_emitted    = r_emitted;
        n_first      = r_first;
        n_cnt        = r_cnt;
        n_run        = r_run;
        n_clr        = r_clr;
        n_clr_addr   = r_clr_addr;
        mem_we       = 1'b0;
        mem_waddr    = r_emitted[AW-1:0];
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = r_emitted[AW-1:0] - w_dist[AW-1:0];
        w_out_load   = 1'b0;
        w_load_pixel = '0;
        w_load_run   = RW'(1);
        w_load_last  = 1'b1;
        w_load_done  = (w_emitted_inc == r_pc);

        unique case (r_state)
            rgblz_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_word  = i_s_axis_tdata;
                    n_state = rgblz_pkg::S_EXEC;
                end
            end
            rgblz_pkg::S_EXEC: begin
                if (w_image_full) begin
                    n_state = rgblz_pkg::S_IDLE;
                end else if (r_first || r_word[rgblz_pkg::LIT_BIT]) begin
                    if (w_out_free) begin
                        mem_we       = 1'b1;
                        mem_wdata    = rgblz_pkg::literal_pixel(r_word, r_swap);
                        w_out_load   = 1'b1;
                        w_load_pixel = mem_wdata;
                        n_emitted    = w_emitted_inc;
                        n_first      = 1'b0;
                        n_state      = rgblz_pkg::S_IDLE;
                    end
                end else if (r_word[rgblz_pkg::REF_BIT]) begin
                    n_cnt   = w_ref_cnt;
                    n_state = rgblz_pkg::S_READ;
                end else if (r_word == '0) begin
                    n_state = rgblz_pkg::S_IDLE;
                end else begin
                    n_run      = w_run_clip;
                    n_clr      = (32'(w_run_clip) >= HISTORY_DEPTH) ? CLRW'(HISTORY_DEPTH)
                                                                    : CLRW'(w_run_clip);
                    n_clr_addr = r_emitted[AW-1:0];
                    n_state    = rgblz_pkg::S_CLEAR;
                end
            end
            rgblz_pkg::S_READ: begin
                mem_re  = 1'b1;
                n_state = rgblz_pkg::S_COPY;
            end
            rgblz_pkg::S_COPY: begin
                if (w_out_free) begin
                    mem_we       = 1'b1;
                    mem_wdata    = w_copy_pixel;
                    w_out_load   = 1'b1;
                    w_load_pixel = w_copy_pixel;
                    w_load_last  = (r_cnt == 4'd1);
                    n_emitted    = w_emitted_inc;
                    n_cnt        = r_cnt - 4'd1;
                    n_state      = (r_cnt == 4'd1) ? rgblz_pkg::S_IDLE : rgblz_pkg::S_READ;
                end
            end
            rgblz_pkg::S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                n_clr      = r_clr - CLRW'(1);
                if (r_clr == CLRW'(1)) begin
                    n_state = rgblz_pkg::S_RUN_OUT;
                end
            end
            rgblz_pkg::S_RUN_OUT: begin
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    w_load_run  = r_run;
                    w_load_done = ((r_emitted + CW'(r_run)) == r_pc);
                    n_emitted   = r_emitted + CW'(r_run);
                    n_state     = rgblz_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rgblz_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rgblz_pkg::S_IDLE;
            r_emitted <= '0;
            r_first   <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_emitted <= n_emitted;
            r_first   <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_cnt      <= n_cnt;
        r_run      <= n_run;
        r_clr      <= n_clr;
        r_clr_addr <= n_clr_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b0;
            r_pc   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rgblz_pkg::CFG_SWAP_RED_BLUE: r_swap <= i_cfg_wdata[0];
                rgblz_pkg::CFG_PIXEL_COUNT:   r_pc   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pixel <= w_load_pixel;
            r_out_run   <= w_load_run;
            r_out_last  <= w_load_last;
            r_out_done  <= w_load_done;
        end
    end

    assign o_s_axis_tready = (r_state == rgblz_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(rgblz_pkg::TDATA_W - PW - RW){1'b0}}, r_out_run, r_out_pixel};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_done;

    // The pixel count only moves together with a result entering the output stage.
    a_emitted_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_emitted != $past(r_emitted))) |-> $past(w_out_load))
        else $error("emitted count changed without a result");

    // Every result leaves the first-word literal behind.
    a_first_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> !r_first)
        else $error("first-word flag still set after a result");

    // A copy is never started with nothing left to copy.
    a_copy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rgblz_pkg::S_READ) |-> (r_cnt != 4'd0))
        else $error("copy read with zero pixels left");

    // The clear sweep always has at least one entry left while it runs.
    a_clear_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rgblz_pkg::S_CLEAR) |-> (r_clr != '0))
        else $error("clear sweep with zero entries left");

endmodule

[sim/rgb555_lz_texture_decoder_tb.sv]
// Self-checking testbench for the RGB555 LZ texture decoder with its own pixel predictor.
`timescale 1ns / 1ps

module rgb555_lz_texture_decoder_tb;

    localparam int WORD_W    = rgblz_pkg::WORD_W;
    localparam int COUNT_W   = rgblz_pkg::COUNT_W;
    localparam int PIXEL_W   = rgblz_pkg::PIXEL_W;
    localparam int RUN_W     = rgblz_pkg::RUN_W;
    localparam int TDATA_W   = rgblz_pkg::TDATA_W;
    localparam int CFG_IDX_W = rgblz_pkg::CFG_IDX_W;

    localparam int HIST_DEPTH   = 2048;
    localparam int SETTLE_TICKS = 2100;      // longest zero run clear plus margin
    localparam int TICK_LIMIT   = 10000000;
    localparam logic [COUNT_W-1:0] MAX_PIXELS = 25'h1000000;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [RUN_W-1:0]   run;
        logic               last;
        logic               done;
    } t_pixel_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = rgblz_pkg::CFG_SWAP_RED_BLUE;
    logic [COUNT_W-1:0]    i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [WORD_W-1:0]     i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_m_axis_tuser;

    // Predictor state.
    logic [PIXEL_W-1:0]    ring_model [HIST_DEPTH] = '{default: '0};
    logic [COUNT_W-1:0]    emitted = '0;
    logic                  first_word_pending = 1'b1;
    logic                  cfg_swap = 1'b0;
    logic [COUNT_W-1:0]    cfg_pixels = '0;
    t_pixel_result         pixel_expect_q [$];

    int send_idle_pct = 29;
    int recv_idle_pct = 81;
    int fails = 0;
    int words_decoded = 0;
    int words_ignored = 0;
    int results_checked = 0;

    rgb555_lz_texture_decoder #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tlast(o_m_axis_tlast),
        .o_m_axis_tuser(o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] widen5(input logic [4:0] v);
        int unsigned scaled;
        scaled = (int'(v) * 255 + 15) / 31;
        return scaled[7:0];
    endfunction

    // Works out the pixels that one accepted code word produces and queues them.
    function automatic int decode_word(input logic [WORD_W-1:0] w);
        int unsigned   remaining;
        int unsigned   count;
        int unsigned   copy_dist;
        int unsigned   run;
        int unsigned   clr;
        logic [7:0]    hi;
        logic [7:0]    mid;
        logic [7:0]    lo;
        t_pixel_result r;
        if (emitted >= cfg_pixels) begin
            return 0;
        end
        remaining = 32'(cfg_pixels - emitted);
        if (first_word_pending || w[rgblz_pkg::LIT_BIT]) begin
            hi  = widen5(w[14:10]);
            mid = widen5(w[9:5]);
            lo  = widen5(w[4:0]);
            r.pixel = cfg_swap ? {8'hFF, hi, mid, lo} : {8'hFF, lo, mid, hi};
            first_word_pending = 1'b0;
            ring_model[11'(emitted)] = r.pixel;
            emitted = emitted + COUNT_W'(1);
            r.run  = RUN_W'(1);
            r.last = 1'b1;
            r.done = (emitted == cfg_pixels);
            pixel_expect_q.push_back(r);
            return 1;
        end
        if (w[rgblz_pkg::REF_BIT]) begin
            count     = int'(w[13:11]) + 2;
            copy_dist = int'(w[10:0]) + 1;
            if (count > remaining) begin
                count = remaining;
            end
            // Each copied pixel lands in the ring before the next one is read.
            for (int i = 0; i < count; i++) begin
                r.pixel = ring_model[11'(32'(emitted) - copy_dist)];
                ring_model[11'(emitted)] = r.pixel;
                emitted = emitted + COUNT_W'(1);
                r.run  = RUN_W'(1);
                r.last = (i + 1 == count);
                r.done = (emitted == cfg_pixels);
                pixel_expect_q.push_back(r);
            end
            return count;
        end
        if (w == '0) begin
            return 0;
        end
        run = 32'(w);
        if (run > remaining) begin
            run = remaining;
        end
        clr = (run < HIST_DEPTH) ? run : HIST_DEPTH;
        for (int i = 0; i < clr; i++) begin
            ring_model[11'(32'(emitted) + 32'(i))] = '0;
        end
        emitted = emitted + COUNT_W'(run);
        r.pixel = '0;
        r.run   = run[RUN_W-1:0];
        r.last  = 1'b1;
        r.done  = (emitted == cfg_pixels);
        pixel_expect_q.push_back(r);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_checked++;
            if (pixel_expect_q.size() == 0) begin
                $error("unexpected pixel item: tdata %h", o_m_axis_tdata);
                fails++;
            end else begin
                e = pixel_expect_q.pop_front();
                if (o_m_axis_tdata[31:0] !== e.pixel) begin
                    $error("pixel_rgba: expected %h, got %h", e.pixel, o_m_axis_tdata[31:0]);
                    fails++;
                end
                if (o_m_axis_tdata[45:32] !== e.run) begin
                    $error("run_length: expected %0d, got %0d", e.run, o_m_axis_tdata[45:32]);
                    fails++;
                end
                if (o_m_axis_tlast !== e.last) begin
                    $error("last_of_word: expected %b, got %b", e.last, o_m_axis_tlast);
                    fails++;
                end
                if (o_m_axis_tuser !== e.done) begin
                    $error("image_done: expected %b, got %b", e.done, o_m_axis_tuser);
                    fails++;
                end
            end
        end
    end

    initial begin
        repeat (TICK_LIMIT) @(posedge i_clk);
        $display("Timeout with %0d pixel items outstanding.", pixel_expect_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_word(input logic [WORD_W-1:0] w, output int produced);
        // The sender holds back in a given share of the cycles.
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= w;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        produced = decode_word(w);
        if (produced == 0) begin
            words_ignored++;
        end else begin
            words_decoded++;
        end
    endtask

    task automatic send_list(input logic [WORD_W-1:0] words [$]);
        int produced;
        foreach (words[i]) begin
            send_word(words[i], produced);
        end
    endtask

    // Lets every outstanding pixel arrive and the sequencer finish any clearing.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pixel_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic program_image(input logic swap, input logic [COUNT_W-1:0] pixels);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rgblz_pkg::CFG_SWAP_RED_BLUE;
        i_cfg_wdata <= {{(COUNT_W-1){1'b0}}, swap};
        @(posedge i_clk);
        cfg_swap = swap;
        i_cfg_index <= rgblz_pkg::CFG_PIXEL_COUNT;
        i_cfg_wdata <= pixels;
        @(posedge i_clk);
        cfg_pixels = pixels;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return {1'b1, 15'($urandom)};
        end else if (pick < 75) begin
            // Half of the references use short distances so that copies overlap.
            if ($urandom_range(1)) begin
                return {2'b01, 3'($urandom), 11'($urandom_range(0, 15))};
            end
            return {2'b01, 14'($urandom)};
        end else if (pick < 90) begin
            return WORD_W'($urandom_range(1, 40));
        end else if (pick < 94) begin
            return WORD_W'($urandom_range(1, 16383));
        end else if (pick < 97) begin
            return '0;
        end
        return WORD_W'($urandom);
    endfunction

    task automatic test_reset_pixel_count();
        // Pixel count is zero out of reset, so nothing may come out.
        send_list('{16'h8000, 16'h7FFF});
        settle();
    endtask

    task automatic test_first_word();
        program_image(1'b0, 25'd40);
        // Looks like a zero run but must be decoded as a literal.
        send_list('{16'h1234});
    endtask

    task automatic test_reference_before_start();
        send_list('{16'h7FFF, 16'h4000});
    endtask

    task automatic test_literal_extremes();
        send_list('{16'h8000, 16'hFFFF, 16'h801F, 16'h83E0, 16'hFC00, 16'hAAAA, 16'hD555});
    endtask

    task automatic test_overlap_copy();
        send_list('{16'h7800, 16'h4802});
    endtask

    task automatic test_zero_runs();
        send_list('{16'h0000, 16'h0001, 16'h0005});
    endtask

    task automatic test_clipping();
        // Three pixels remain, so the nine-pixel copy is cut and the image completes.
        send_list('{16'h7FFF, 16'h8000});
        settle();
    endtask

    task automatic test_swap_and_ring_clear();
        program_image(1'b1, emitted + 25'd20000);
        send_list('{16'hFC00, 16'h801F, 16'h3FFF, 16'h7FFF});
        settle();
    endtask

    task automatic test_count_lowered();
        program_image(1'b0, emitted - 25'd5);
        send_list('{16'h8001});
        settle();
    endtask

    task automatic run_random_traffic(input int n_words, input bit reach_max);
        int taken;
        int produced;
        logic [COUNT_W-1:0] limit;
        taken = 0;
        while (taken < n_words) begin
            if (reach_max && taken >= n_words / 2) begin
                limit = MAX_PIXELS;
            end else begin
                limit = emitted + COUNT_W'($urandom_range(20, 500));
            end
            program_image(1'($urandom), limit);
            while (taken < n_words && emitted < cfg_pixels) begin
                send_word(random_word(), produced);
                if (produced != 0) begin
                    taken++;
                end
            end
            // A finished image must swallow whatever follows.
            if (emitted >= cfg_pixels) begin
                repeat ($urandom_range(1, 2)) send_word(random_word(), produced);
            end
            settle();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_pixel_count();
        test_first_word();
        test_reference_before_start();
        test_literal_extremes();
        test_overlap_copy();
        test_zero_runs();
        test_clipping();
        test_swap_and_ring_clear();
        test_count_lowered();

        run_random_traffic(140, 1'b0);
        send_idle_pct = 81;
        recv_idle_pct = 29;
        run_random_traffic(140, 1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(140, 1'b1);

        $display("Decoded %0d code words into %0d checked pixel items, %0d words ignored.",
                 words_decoded, results_checked, words_ignored);
        $display("Covered both channel orders, clipped images, overlapping copies, ring-wide ",
                 "zero runs and pixel counts from zero up to the maximum.");
        if (fails == 0 && pixel_expect_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d pixel items missing.", fails, pixel_expect_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
